FILE: design/eti_pkg.sv
// Shared types and codes for the entropy table integrator.
package eti_pkg;

  typedef logic [1:0] div_sel_t;
  localparam div_sel_t DIV_PRES   = 2'd0;
  localparam div_sel_t DIV_RATIO  = 2'd1;
  localparam div_sel_t DIV_COLUMN = 2'd2;
  localparam div_sel_t DIV_ROW    = 2'd3;

  typedef logic [0:0] reg_index_t;
  localparam reg_index_t REG_DENSITY_COUNT     = 1'b0;
  localparam reg_index_t REG_TEMPERATURE_COUNT = 1'b1;

  typedef struct packed {
    logic     capture;
    logic     div_start;
    div_sel_t div_sel;
    logic     take_ratio1;
    logic     take_ratio;
    logic     prep;
    logic     acc_row_start;
    logic     mul_start;
    logic     make_num;
    logic     acc_running;
    logic     commit;
  } eti_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic col_step;
    logic row_step;
    logic out_free;
  } eti_sts_t;

endpackage

FILE: design/eti_if.sv
// Item channels for grid points and entropy results.
interface eti_point_if #(parameter int W = 48);
  logic                valid;
  logic                ready;
  logic        [W-1:0] density;
  logic        [W-1:0] temperature;
  logic signed [W-1:0] pressure;
  logic signed [W-1:0] energy;
  modport source (output valid, density, temperature, pressure, energy, input ready);
  modport sink   (input valid, density, temperature, pressure, energy, output ready);
endinterface

interface eti_result_if #(parameter int W = 48, parameter int C = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] entropy;
  logic        [C-1:0] density_index;
  logic        [C-1:0] temperature_index;
  logic                run_last;
  logic                table_done;
  modport source (output valid, entropy, density_index, temperature_index, run_last,
                  table_done, input ready);
  modport sink   (input valid, entropy, density_index, temperature_index, run_last,
                  table_done, output ready);
endinterface

FILE: design/eti_div.sv
// Restoring divider, one quotient bit per cycle, signed saturated result.
module eti_div #(
  parameter int W = 48,
  parameter int F = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic        [W-1:0] n_mag,
  input  logic                neg,
  input  logic                sh_extra,
  input  logic        [W:0]   den,
  output logic                done,
  output logic signed [W-1:0] quot
);
  localparam int NW = W + F + 1;
  localparam int CW = $clog2(NW + 1);
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  logic          busy, fin, neg_r, dz;
  logic [CW-1:0] cnt;
  logic [NW-1:0] acc;
  logic [W:0]    rem, den_r;
  logic [W+1:0]  trial, diff;
  logic          ge;

  assign trial = {rem, acc[NW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        den_r <= den;
        neg_r <= neg;
        dz    <= den == '0;
        acc   <= sh_extra ? {n_mag, {(F+1){1'b0}}} : {1'b0, n_mag, {F{1'b0}}};
      end else if (busy) begin
        rem <= ge ? diff[W:0] : trial[W:0];
        acc <= {acc[NW-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
      if (fin) begin
        done <= 1'b1;
        if (dz) begin
          quot <= neg_r ? VMIN : VMAX;
        end else if (neg_r) begin
          if (acc > {{(NW-W){1'b0}}, 1'b1, {(W-1){1'b0}}}) quot <= VMIN;
          else quot <= -$signed(acc[W-1:0]);
        end else begin
          if (acc > {{(NW-W+1){1'b0}}, {(W-1){1'b1}}}) quot <= VMAX;
          else quot <= $signed(acc[W-1:0]);
        end
      end
    end
  end
endmodule

FILE: design/eti_datapath.sv
// Datapath: table state, serial multiplier, divider and result register.
module eti_datapath #(
  parameter int W = 48,
  parameter int F = 24,
  parameter int C = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  eti_pkg::eti_cmd_t     cmd,
  output eti_pkg::eti_sts_t     sts,
  input  logic                  wr_en,
  input  eti_pkg::reg_index_t   wr_index,
  input  logic          [C-1:0] wr_data,
  input  logic          [W-1:0] in_density,
  input  logic          [W-1:0] in_temperature,
  input  logic signed   [W-1:0] in_pressure,
  input  logic signed   [W-1:0] in_energy,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic signed   [W-1:0] out_entropy,
  output logic          [C-1:0] out_density_index,
  output logic          [C-1:0] out_temperature_index,
  output logic                  out_run_last,
  output logic                  out_table_done
);
  import eti_pkg::*;

  localparam int PW = 2 * W - F;
  localparam int MC = $clog2(W + 1);
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] clamp(input logic signed [W:0] x);
    logic signed [W:0] hi, lo;
    hi = {1'b0, VMAX};
    lo = {1'b1, VMIN};
    if (x > hi) return VMAX;
    if (x < lo) return VMIN;
    return x[W-1:0];
  endfunction

  function automatic logic [W-1:0] smag(input logic signed [W-1:0] x);
    logic signed [W-1:0] n;
    n = -x;
    return x[W-1] ? n : x;
  endfunction

  logic        [C-1:0] dcount, tcount, col, row;
  logic                skip, zfirst;
  logic        [W-1:0] rho, temp, prior_t, prev_rho;
  logic signed [W-1:0] pres, energy, row_start, prior_e, prev_e, prev_ratio, running;
  logic signed [W-1:0] ratio1, ratio, num_r, de_r, drho_r, pavg_r;

  logic [2*W-1:0] macc;
  logic [W-1:0]   ma, mb;
  logic           mneg, mbusy, mdone;
  logic [MC-1:0]  mcnt;

  logic               o_pend, o_pend_td;

  logic               is_start, is_after, zero_now, last_col, tbl_done, emit;
  logic [C-1:0]       start_col;
  logic signed [W-1:0] diff_ce, de, drho, psum, pavg, prod, num;
  logic signed [W:0]   ph;
  logic [W-1:0]        dm;
  logic [PW-1:0]       pm;

  logic                div_done;
  logic signed [W-1:0] dq;
  logic        [W-1:0] dn_mag;
  logic signed [W-1:0] dn;
  logic                dsh;
  logic        [W:0]   dden;

  assign start_col = {{(C-1){1'b0}}, skip};
  assign is_start  = col == start_col;
  assign is_after  = col > start_col;
  assign zero_now  = zfirst && (row == '0);
  assign last_col  = ({1'b0, col} + 1'b1) >= {1'b0, dcount};
  assign tbl_done  = last_col && (({1'b0, row} + 1'b1) >= {1'b0, tcount});
  assign emit      = cmd.commit && (is_start || is_after);

  assign sts.div_done = div_done;
  assign sts.mul_done = mdone;
  assign sts.col_step = is_start && (row != '0) && !zero_now;
  assign sts.row_step = is_after && !zero_now;
  assign sts.out_free = !out_valid || (out_ready && !o_pend);

  always_comb begin
    diff_ce = clamp({energy[W-1], energy} - {prior_e[W-1], prior_e});
    de      = clamp({energy[W-1], energy} - {prev_e[W-1], prev_e});
    dm      = (rho >= prev_rho) ? rho - prev_rho : prev_rho - rho;
    if (rho < prev_rho) begin
      if (dm > {1'b1, {(W-1){1'b0}}}) drho = VMIN;
      else drho = -$signed(dm);
    end else begin
      if (dm > VMAX) drho = VMAX;
      else drho = $signed(dm);
    end
    psum = clamp({ratio[W-1], ratio} + {prev_ratio[W-1], prev_ratio});
    ph   = {psum[W-1], psum} + {{W{1'b0}}, psum[W-1]};
    pavg = ph[W:1];
    pm   = macc[2*W-1:F];
    if (mneg) begin
      if (pm > {{(PW-W){1'b0}}, 1'b1, {(W-1){1'b0}}}) prod = VMIN;
      else prod = -$signed(pm[W-1:0]);
    end else begin
      if (pm > {{(PW-W+1){1'b0}}, {(W-1){1'b1}}}) prod = VMAX;
      else prod = $signed(pm[W-1:0]);
    end
    num = clamp({de_r[W-1], de_r} - {prod[W-1], prod});
  end

  always_comb begin
    unique case (cmd.div_sel)
      DIV_PRES: begin
        dn = pres; dsh = 1'b0; dden = {1'b0, rho};
      end
      DIV_RATIO: begin
        dn = ratio1; dsh = 1'b0; dden = {1'b0, rho};
      end
      DIV_COLUMN: begin
        dn = num_r; dsh = 1'b1; dden = {1'b0, temp} + {1'b0, prior_t};
      end
      DIV_ROW: begin
        dn = num_r; dsh = 1'b0; dden = {1'b0, temp};
      end
      default: begin
        dn = pres; dsh = 1'b0; dden = {1'b0, rho};
      end
    endcase
    dn_mag = smag(dn);
  end

  eti_div #(.W(W), .F(F)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .n_mag    (dn_mag),
    .neg      (dn[W-1]),
    .sh_extra (dsh),
    .den      (dden),
    .done     (div_done),
    .quot     (dq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mdone <= 1'b0;
    end else begin
      mdone <= 1'b0;
      if (cmd.mul_start) begin
        mbusy <= 1'b1;
        mcnt  <= '0;
        macc  <= '0;
        ma    <= smag(pavg_r);
        mb    <= smag(drho_r);
        mneg  <= pavg_r[W-1] != drho_r[W-1];
      end else if (mbusy) begin
        macc <= {macc[2*W-2:0], 1'b0} + (mb[W-1] ? {{W{1'b0}}, ma} : '0);
        mb   <= {mb[W-2:0], 1'b0};
        mcnt <= mcnt + 1'b1;
        if (mcnt == MC'(W - 1)) begin
          mbusy <= 1'b0;
          mdone <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcount     <= C'(1);
      tcount     <= C'(1);
      col        <= '0;
      row        <= '0;
      skip       <= 1'b0;
      zfirst     <= 1'b0;
      row_start  <= '0;
      prior_t    <= '0;
      prior_e    <= '0;
      prev_e     <= '0;
      prev_rho   <= '0;
      prev_ratio <= '0;
      running    <= '0;
      out_valid  <= 1'b0;
      o_pend     <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_DENSITY_COUNT:     dcount <= wr_data;
          REG_TEMPERATURE_COUNT: tcount <= wr_data;
          default: ;
        endcase
      end
      if (cmd.capture) begin
        rho    <= in_density;
        temp   <= in_temperature;
        pres   <= in_pressure;
        energy <= in_energy;
        if (col == '0 && row == '0) begin
          skip      <= (in_density == '0) && (dcount > C'(1));
          zfirst    <= in_temperature == '0;
          row_start <= '0;
          running   <= '0;
        end
      end
      if (cmd.take_ratio1) ratio1 <= dq;
      if (cmd.take_ratio) ratio <= dq;
      if (cmd.prep) begin
        num_r  <= diff_ce;
        de_r   <= de;
        drho_r <= drho;
        pavg_r <= pavg;
      end
      if (cmd.make_num) num_r <= num;
      if (cmd.acc_row_start) row_start <= clamp({row_start[W-1], row_start} + {dq[W-1], dq});
      if (cmd.acc_running) running <= clamp({running[W-1], running} + {dq[W-1], dq});

      if (out_valid && out_ready) begin
        if (o_pend) begin
          out_density_index <= C'(1);
          out_run_last      <= 1'b1;
          out_table_done    <= o_pend_td;
          o_pend            <= 1'b0;
        end else if (!emit) begin
          out_valid <= 1'b0;
        end
      end

      if (cmd.commit) begin
        prev_e     <= energy;
        prev_rho   <= rho;
        prev_ratio <= ratio;
        if (is_start) begin
          prior_t <= temp;
          prior_e <= energy;
          running <= row_start;
        end
        if (emit) begin
          out_valid             <= 1'b1;
          out_entropy           <= is_start ? row_start : running;
          out_temperature_index <= row;
          if (is_start && skip) begin
            out_density_index <= '0;
            out_run_last      <= 1'b0;
            out_table_done    <= 1'b0;
            o_pend            <= 1'b1;
            o_pend_td         <= tbl_done;
          end else begin
            out_density_index <= col;
            out_run_last      <= 1'b1;
            out_table_done    <= tbl_done;
            o_pend            <= 1'b0;
          end
        end
        if (last_col) begin
          col <= '0;
          row <= tbl_done ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end
endmodule

FILE: design/eti_ctrl.sv
// Controller: sequences the divisions, the multiply and the commit of one item.
module eti_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              ready,
  input  eti_pkg::eti_sts_t sts,
  output eti_pkg::eti_cmd_t cmd
);
  import eti_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_D1     = 4'd1;
  localparam logic [3:0] S_W1     = 4'd2;
  localparam logic [3:0] S_D2     = 4'd3;
  localparam logic [3:0] S_W2     = 4'd4;
  localparam logic [3:0] S_PREP   = 4'd5;
  localparam logic [3:0] S_D3     = 4'd6;
  localparam logic [3:0] S_W3     = 4'd7;
  localparam logic [3:0] S_MS     = 4'd8;
  localparam logic [3:0] S_WM     = 4'd9;
  localparam logic [3:0] S_NUM    = 4'd10;
  localparam logic [3:0] S_D4     = 4'd11;
  localparam logic [3:0] S_W4     = 4'd12;
  localparam logic [3:0] S_COMMIT = 4'd13;

  logic [3:0] state, state_next;

  assign ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    cmd.div_sel = DIV_PRES;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_D1;
        end
      end
      S_D1: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_PRES;
        state_next    = S_W1;
      end
      S_W1: begin
        if (sts.div_done) begin
          cmd.take_ratio1 = 1'b1;
          state_next      = S_D2;
        end
      end
      S_D2: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RATIO;
        state_next    = S_W2;
      end
      S_W2: begin
        if (sts.div_done) begin
          cmd.take_ratio = 1'b1;
          state_next     = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (sts.col_step) state_next = S_D3;
        else if (sts.row_step) state_next = S_MS;
        else state_next = S_COMMIT;
      end
      S_D3: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_COLUMN;
        state_next    = S_W3;
      end
      S_W3: begin
        if (sts.div_done) begin
          cmd.acc_row_start = 1'b1;
          state_next        = S_COMMIT;
        end
      end
      S_MS: begin
        cmd.mul_start = 1'b1;
        state_next    = S_WM;
      end
      S_WM: begin
        if (sts.mul_done) state_next = S_NUM;
      end
      S_NUM: begin
        cmd.make_num = 1'b1;
        state_next   = S_D4;
      end
      S_D4: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ROW;
        state_next    = S_W4;
      end
      S_W4: begin
        if (sts.div_done) begin
          cmd.acc_running = 1'b1;
          state_next      = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

FILE: design/entropy_table_integrator.sv
// Top level: entropy integration over an equation-of-state table, one point at a time.
// Divisions and the multiply are bit-serial; accept to result is longest along a row
// (three divisions and the multiply), shorter with a column step (three divisions)
// and shortest with no integration step (two divisions).
// One point is in work at a time; a waiting result holds the commit of the next point.
// Synchronous reset clears counters, table state, flags, and sets both counts to 1.
module entropy_table_integrator #(
  parameter int VALUE_WIDTH   = 48,
  parameter int FRACTION_BITS = 24,
  parameter int COUNT_WIDTH   = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  eti_point_if.sink                point,
  eti_result_if.source             result,
  input  logic                     wr_en,
  input  eti_pkg::reg_index_t      wr_index,
  input  logic [COUNT_WIDTH-1:0]   wr_data
);
  import eti_pkg::*;

  eti_cmd_t cmd;
  eti_sts_t sts;

  eti_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (point.valid),
    .ready    (point.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  eti_datapath #(.W(VALUE_WIDTH), .F(FRACTION_BITS), .C(COUNT_WIDTH)) u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .cmd                   (cmd),
    .sts                   (sts),
    .wr_en                 (wr_en),
    .wr_index              (wr_index),
    .wr_data               (wr_data),
    .in_density            (point.density),
    .in_temperature        (point.temperature),
    .in_pressure           (point.pressure),
    .in_energy             (point.energy),
    .out_ready             (result.ready),
    .out_valid             (result.valid),
    .out_entropy           (result.entropy),
    .out_density_index     (result.density_index),
    .out_temperature_index (result.temperature_index),
    .out_run_last          (result.run_last),
    .out_table_done        (result.table_done)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    point.valid && point.ready |=> !point.ready)
    else $error("point taken while previous still in work");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> sts.out_free)
    else $error("commit into occupied result register");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(sts.div_done && sts.mul_done))
    else $error("divider and multiplier finished together");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.table_done |-> result.run_last)
    else $error("table end on a non-final result");

endmodule

FILE: tb/entropy_table_integrator_tb.sv
// Testbench for entropy_table_integrator: directed and random grid tables against a local entropy predictor.
`timescale 1ns / 1ps

module entropy_table_integrator_tb;
  import eti_pkg::*;

  localparam int VW = 48;
  localparam int FB = 24;
  localparam int CW = 16;
  localparam longint VMAX = (64'sd1 <<< (VW - 1)) - 1;
  localparam longint VMIN = -VMAX - 1;
  localparam int SETTLE = 400;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [VW-1:0]        density;
    logic [VW-1:0]        temperature;
    logic signed [VW-1:0] pressure;
    logic signed [VW-1:0] energy;
  } grid_point_t;

  typedef struct {
    logic signed [VW-1:0] entropy;
    logic [CW-1:0]        density_index;
    logic [CW-1:0]        temperature_index;
    logic                 run_last;
    logic                 table_done;
  } entropy_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  reg_index_t wr_index = REG_DENSITY_COUNT;
  logic [CW-1:0] wr_data = '0;

  eti_point_if #(.W(VW)) point ();
  eti_result_if #(.W(VW), .C(CW)) result ();

  entropy_table_integrator u_top (
    .clk     (clk),
    .rst     (rst),
    .point   (point),
    .result  (result),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  grid_point_t     pending_points[$];
  entropy_result_t expected_entropy[$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  calm = 1'b0;

  // predictor state
  int     dens_count = 1, temp_count = 1;
  int     col_ctr = 0, row_ctr = 0;
  bit     skip_col0 = 0, zero_row0 = 0;
  longint row_start_s = 0, run_s = 0, prior_start_e = 0, prev_e = 0, prev_ratio = 0;
  logic [63:0] prior_t = 0, prev_rho = 0;

  function automatic longint clampv(longint x);
    if (x > VMAX) return VMAX;
    if (x < VMIN) return VMIN;
    return x;
  endfunction

  function automatic logic [63:0] magnitude(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic longint signed_of_mag(logic [127:0] m, bit neg);
    if (neg) begin
      if (m > 128'(VMAX) + 1) return VMIN;
      return -longint'(m[63:0]);
    end
    if (m > 128'(VMAX)) return VMAX;
    return longint'(m[63:0]);
  endfunction

  function automatic longint quot_sat(logic [63:0] nmag, bit neg, int sh, logic [63:0] d);
    logic [127:0] n, q;
    if (d == 0) return neg ? VMIN : VMAX;
    n = {64'b0, nmag} << sh;
    q = n / {64'b0, d};
    return signed_of_mag(q, neg && q != 0);
  endfunction

  function automatic longint fix_div(longint n, logic [63:0] d);
    return quot_sat(magnitude(n), n < 0, FB, d);
  endfunction

  function automatic longint fix_mul(longint a, longint b);
    logic [127:0] p;
    p = ({64'b0, magnitude(a)} * {64'b0, magnitude(b)}) >> FB;
    return signed_of_mag(p, (a < 0) != (b < 0));
  endfunction

  task automatic predict_entropy(grid_point_t pt);
    logic [63:0] rho, temp, dm;
    longint pres, en, ratio, diff, de, drho, pavg, num;
    int col, row, start_col, n;
    bit last_col, done, zero_now;
    entropy_result_t r;
    rho = 64'(pt.density);
    temp = 64'(pt.temperature);
    pres = longint'(pt.pressure);
    en = longint'(pt.energy);
    col = col_ctr;
    row = row_ctr;
    n = 0;
    last_col = col + 1 >= dens_count;
    done = last_col && row + 1 >= temp_count;
    if (col == 0 && row == 0) begin
      skip_col0 = (rho == 0) && dens_count >= 2;
      zero_row0 = (temp == 0);
      row_start_s = 0;
      run_s = 0;
    end
    start_col = skip_col0 ? 1 : 0;
    zero_now = zero_row0 && row == 0;
    ratio = fix_div(fix_div(pres, rho), rho);
    if (col == start_col) begin
      if (row != 0 && !zero_now) begin
        diff = clampv(en - prior_start_e);
        row_start_s = clampv(row_start_s +
                             quot_sat(magnitude(diff), diff < 0, FB + 1, temp + prior_t));
      end
      prior_t = temp;
      prior_start_e = en;
      run_s = row_start_s;
      n = skip_col0 ? 2 : 1;
    end else if (col > start_col) begin
      if (!zero_now) begin
        de = clampv(en - prev_e);
        dm = rho >= prev_rho ? rho - prev_rho : prev_rho - rho;
        drho = signed_of_mag({64'b0, dm}, rho < prev_rho);
        pavg = clampv(ratio + prev_ratio) / 2;
        num = clampv(de - fix_mul(pavg, drho));
        run_s = clampv(run_s + fix_div(num, temp));
      end
      n = 1;
    end
    prev_e = en;
    prev_rho = rho;
    prev_ratio = ratio;
    for (int k = 0; k < n; k++) begin
      r.entropy = run_s[VW-1:0];
      r.density_index = (n == 2) ? CW'(k) : CW'(col);
      r.temperature_index = CW'(row);
      r.run_last = (k == n - 1);
      r.table_done = (k == n - 1) && done;
      expected_entropy.push_back(r);
    end
    if (last_col) begin
      col_ctr = 0;
      row_ctr = done ? 0 : ((row + 1) & 16'hffff);
    end else begin
      col_ctr = (col + 1) & 16'hffff;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      point.valid <= 1'b0;
    end else begin
      if (point.valid && point.ready) begin
        predict_entropy('{point.density, point.temperature, point.pressure, point.energy});
      end
      if (!point.valid || point.ready) begin
        if (pending_points.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
          grid_point_t pt;
          pt = pending_points.pop_front();
          point.valid <= 1'b1;
          point.density <= pt.density;
          point.temperature <= pt.temperature;
          point.pressure <= pt.pressure;
          point.energy <= pt.energy;
        end else begin
          point.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      result.ready <= calm || $urandom_range(99) >= 13;
      if (result.valid && result.ready) begin
        if (expected_entropy.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: entropy %0d col %0d row %0d", result.entropy,
                     result.density_index, result.temperature_index);
        end else begin
          entropy_result_t e;
          e = expected_entropy.pop_front();
          if (result.entropy !== e.entropy || result.density_index !== e.density_index ||
              result.temperature_index !== e.temperature_index ||
              result.run_last !== e.run_last || result.table_done !== e.table_done) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp S=%0d c=%0d r=%0d last=%0b done=%0b, ",
                        "got S=%0d c=%0d r=%0d last=%0b done=%0b"},
                       e.entropy, e.density_index, e.temperature_index, e.run_last,
                       e.table_done, result.entropy, result.density_index,
                       result.temperature_index, result.run_last, result.table_done);
          end
        end
      end
    end
  end

  function automatic logic [VW-1:0] any48();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [VW-1:0] modest_signed();
    logic signed [VW-1:0] v;
    v = VW'($urandom_range(0, 32'h3fff_ffff));
    return $urandom_range(1) ? -v : v;
  endfunction

  task automatic add_point(logic [VW-1:0] d, logic [VW-1:0] t,
                           logic signed [VW-1:0] p, logic signed [VW-1:0] e);
    grid_point_t pt;
    pt.density = d;
    pt.temperature = t;
    pt.pressure = p;
    pt.energy = e;
    pending_points.push_back(pt);
  endtask

  // one well-formed table with random content
  task automatic add_table(int dc, int tc, bit zero_rho0, bit zero_t0);
    logic [VW-1:0] t, d;
    for (int r = 0; r < tc; r++) begin
      t = (r == 0 && zero_t0) ? '0 : VW'($urandom_range(1, 32'h7fff_ffff)) * (r + 1);
      if ($urandom_range(19) == 0) t = any48();
      d = VW'($urandom_range(1, 32'h00ff_ffff));
      for (int c = 0; c < dc; c++) begin
        if (c == 0 && zero_rho0) add_point('0, t, modest_signed(), modest_signed());
        else if ($urandom_range(15) == 0) add_point(any48(), t, any48(), any48());
        else add_point(d, t, modest_signed(), modest_signed());
        d = d + VW'($urandom_range(1, 32'h0fff_ffff));
      end
    end
  endtask

  task automatic write_reg(reg_index_t idx, logic [CW-1:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == REG_DENSITY_COUNT) dens_count = val;
    else temp_count = val;
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || point.valid || expected_entropy.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_counts(int dc, int tc);
    drain();
    write_reg(REG_DENSITY_COUNT, CW'(dc));
    write_reg(REG_TEMPERATURE_COUNT, CW'(tc));
  endtask

  localparam logic signed [VW-1:0] SMAX = VMAX[VW-1:0];
  localparam logic signed [VW-1:0] SMIN = VMIN[VW-1:0];

  initial begin
    int dc, tc;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: default counts, then small tables with the special cases
    add_point('0, '0, SMAX, SMIN);
    add_point('1, '1, SMIN, SMAX);
    set_counts(3, 2);
    add_point('0, '0, 48'sd1 <<< 24, 48'sd5 <<< 24);
    add_point(48'd1 << 24, '0, 48'sd2 <<< 24, 48'sd7 <<< 24);
    add_point(48'd2 << 24, '0, SMIN, SMAX);
    add_point('0, 48'd3 << 24, '0, 48'sd9 <<< 24);
    add_point(48'd1 << 24, 48'd3 << 24, SMAX, SMIN);
    add_point('1, 48'd3 << 24, SMIN, SMAX);
    add_table(3, 2, 0, 0);
    add_point('1, '1, SMAX, SMAX);
    add_point(48'd1, '1, SMIN, SMIN);
    add_point('0, 48'd1, SMIN, SMAX);
    add_point('1, '1, SMIN, SMAX);
    add_point(48'd1, '0, SMAX, SMIN);
    add_point('0, 48'd1, SMAX, SMIN);
    set_counts(0, 0);
    add_point('0, 48'd5 << 24, SMAX, SMIN);
    add_point(48'd1, '0, SMIN, SMAX);
    set_counts(65535, 65535);
    add_table(4, 1, 1, 0);
    set_counts(2, 3);
    add_table(2, 3, 0, 1);

    // random phases
    for (int ph = 0; ph < 30; ph++) begin
      dc = $urandom_range(1, 8);
      tc = $urandom_range(1, 6);
      if (ph == 12) begin
        dc = 65535;
        tc = 1;
      end
      set_counts(dc, tc);
      calm = (ph >= 8 && ph < 11);
      if (ph == 12) begin
        add_table(5, 1, $urandom_range(1), 0);
      end else begin
        for (int k = 0; k < 6 && pending_points.size() < 28; k++)
          add_table(dc, tc, $urandom_range(3) == 0, $urandom_range(6) == 0);
        for (int k = 0; k < 3; k++)
          add_point(any48(), any48(), any48(), any48());
      end
    end
    calm = 1'b0;
    drain();

    if (mismatches == 0 && expected_entropy.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: entropy_table_integrator.f
design/eti_pkg.sv
design/eti_if.sv
design/eti_div.sv
design/eti_datapath.sv
design/eti_ctrl.sv
design/entropy_table_integrator.sv
tb/entropy_table_integrator_tb.sv
